// ----- hw/rtl/gbfs_pkg.sv -----
// Shared types and constants for the grid best-first path search block.
// No dependencies; every other file of the block depends on this package.
package gbfs_pkg;

    localparam int OUT_W  = 13;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 7;

    localparam logic [OUT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GOAL = 2'd2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

    typedef enum logic {
        REG_ROWS_USED = 1'b0,
        REG_COLS_USED = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        NB_DOWN  = 2'd0,
        NB_UP    = 2'd1,
        NB_RIGHT = 2'd2,
        NB_LEFT  = 2'd3
    } nb_dir_t;

    typedef struct packed {
        logic load;
        logic clr;
        logic init;
        logic scan_rst;
        logic scan;
        logic close;
        logic nb_next;
        logic h_load;
        logic h_step;
        logic nb_write;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic have;
        logic at_goal;
        logic nb_inside;
        logic nb_free;
        logic nb_last;
        logic h_last;
    } dp_sts_t;

endpackage

// ----- hw/rtl/gbfs_if.sv -----
// Valid/ready channel interfaces for request items and result items.
// Depends on gbfs_pkg for the field widths.
interface gbfs_item_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [gbfs_pkg::ROW_W-1:0]  row;
    logic [gbfs_pkg::COL_W-1:0]  col;
    logic [gbfs_pkg::KIND_W-1:0] cell_kind;

    modport source (output valid, output op, output row, output col, output cell_kind,
                    input ready);
    modport sink (input valid, input op, input row, input col, input cell_kind,
                  output ready);
endinterface

interface gbfs_result_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [gbfs_pkg::OUT_W-1:0] path_length;
    logic [gbfs_pkg::OUT_W-1:0] closed_count;

    modport source (output valid, output found, output path_length, output closed_count,
                    input ready);
    modport sink (input valid, input found, input path_length, input closed_count,
                  output ready);
endinterface

// ----- hw/rtl/gbfs_ctrl.sv -----
// Sequencing state machine of the path search: clear, scan, expand, report.
// Depends on gbfs_pkg for the command and status structures.
module gbfs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_op,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  gbfs_pkg::dp_sts_t sts,
    output gbfs_pkg::dp_cmd_t cmd
);
    import gbfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_INIT,
        S_SCAN_SETUP,
        S_SCAN,
        S_PICK,
        S_NB_ADDR,
        S_NB_CHECK,
        S_H_ROOT,
        S_NB_WRITE,
        S_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && item_valid && (item_op == OP_LOAD);
        cmd.clr      = (state_reg == S_CLEAR);
        cmd.init     = (state_reg == S_INIT);
        cmd.scan_rst = (state_reg == S_SCAN_SETUP);
        cmd.scan     = (state_reg == S_SCAN);
        cmd.close    = (state_reg == S_PICK) && sts.have && !sts.at_goal;
        cmd.nb_next  = ((state_reg == S_NB_ADDR) && !sts.nb_inside)
                    || ((state_reg == S_NB_CHECK) && !sts.nb_free)
                    || (state_reg == S_NB_WRITE);
        cmd.h_load   = (state_reg == S_NB_CHECK) && sts.nb_free;
        cmd.h_step   = (state_reg == S_H_ROOT);
        cmd.nb_write = (state_reg == S_NB_WRITE);
        cmd.res_load = (state_reg == S_REPORT) && (!out_valid_reg || result_ready);
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && (item_op == OP_RUN))
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:       state_next = S_SCAN_SETUP;
            S_SCAN_SETUP: state_next = S_SCAN;
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = (!sts.have || sts.at_goal) ? S_REPORT : S_NB_ADDR;
            end
            S_NB_ADDR:
            begin
                if (sts.nb_inside)
                begin
                    state_next = S_NB_CHECK;
                end
                else if (sts.nb_last)
                begin
                    state_next = S_SCAN_SETUP;
                end
            end
            S_NB_CHECK:
            begin
                if (sts.nb_free)
                begin
                    state_next = S_H_ROOT;
                end
                else
                begin
                    state_next = sts.nb_last ? S_SCAN_SETUP : S_NB_ADDR;
                end
            end
            S_H_ROOT:
            begin
                if (sts.h_last)
                begin
                    state_next = S_NB_WRITE;
                end
            end
            S_NB_WRITE:
            begin
                state_next = sts.nb_last ? S_SCAN_SETUP : S_NB_ADDR;
            end
            S_REPORT:
            begin
                if (cmd.res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten while still held");
    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (item_op == OP_RUN)) |=> (state_reg == S_CLEAR))
        else $error("run request did not start the clearing sweep");
    a_empty_reports: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PICK) && !sts.have) |=> (state_reg == S_REPORT))
        else $error("empty open set did not end the search");
`endif

endmodule

// ----- hw/rtl/gbfs_datapath.sv -----
// Datapath of the path search: maze, mark and cost memories, open-cell scan,
// neighbour generation and the bit-serial square root. Depends on gbfs_pkg.
module gbfs_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbfs_pkg::dp_cmd_t             cmd,
    output gbfs_pkg::dp_sts_t             sts,
    input  logic [gbfs_pkg::ROW_W-1:0]    item_row,
    input  logic [gbfs_pkg::COL_W-1:0]    item_col,
    input  logic [gbfs_pkg::KIND_W-1:0]   item_kind,
    input  logic [gbfs_pkg::CFG_W-1:0]    rows_used,
    input  logic [gbfs_pkg::CFG_W-1:0]    cols_used,
    output logic                          res_found,
    output logic [gbfs_pkg::OUT_W-1:0]    res_path_length,
    output logic [gbfs_pkg::OUT_W-1:0]    res_closed_count
);
    import gbfs_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = (RW > CW) ? RW : CW;
    localparam int HW    = DW + 1;
    localparam int SW    = 2 * DW + 1;
    localparam int PW    = 2 * HW;
    localparam int BW    = $clog2(HW);
    localparam int GW    = AW;
    localparam int FW    = AW + 1;
    localparam int NRW   = RW + 1;
    localparam int NCW   = CW + 1;
    localparam int XW    = (AW + 1 > OUT_W) ? AW + 1 : OUT_W;

    // Memories: maze kinds, open/closed marks (bit 0 open, bit 1 closed), g and f.
    logic [KIND_W-1:0] map_mem  [DEPTH];
    logic [1:0]        stat_mem [DEPTH];
    logic [GW+FW-1:0]  cost_mem [DEPTH];

    logic [KIND_W-1:0] map_rd_reg;
    logic [1:0]        stat_rd_reg;
    logic [GW+FW-1:0]  cost_rd_reg;

    logic [RW-1:0]  goal_r_reg, best_r_reg, scan_r_reg, pr_reg;
    logic [CW-1:0]  goal_c_reg, best_c_reg, scan_c_reg, pc_reg;
    logic [FW-1:0]  best_f_reg;
    logic [GW-1:0]  best_g_reg;
    logic           have_reg, issue_done_reg, pv_reg, first_reg;
    logic [AW-1:0]  clr_idx_reg;
    logic [AW:0]    cnt_reg;
    nb_dir_t        k_reg;
    logic [SW-1:0]  sum_reg;
    logic [HW-1:0]  root_reg;
    logic [BW-1:0]  bi_reg;

    logic [NRW-1:0] nr;
    logic [NCW-1:0] nc;
    logic           ld_ok;
    logic [RW-1:0]  ld_r, tr, dr;
    logic [CW-1:0]  ld_c, tc, dc;
    logic           nb_inside;
    logic [AW-1:0]  nb_addr, scan_addr, rd_addr, stat_wa;
    logic           stat_we;
    logic [1:0]     stat_wd;
    logic           scan_last, row_end;
    logic [FW-1:0]  rd_f;
    logic [GW-1:0]  rd_g, g_new;
    logic [SW-1:0]  sum;
    logic [HW-1:0]  trial;
    logic [XW-1:0]  plen_x, cnt_x;

    always_comb
    begin
        if (rows_used == '0)
            nr = NRW'(1);
        else if (int'(rows_used) > MAX_ROWS)
            nr = NRW'(MAX_ROWS);
        else
            nr = NRW'(rows_used);
        if (cols_used == '0)
            nc = NCW'(1);
        else if (int'(cols_used) > MAX_COLS)
            nc = NCW'(MAX_COLS);
        else
            nc = NCW'(cols_used);
    end

    assign ld_ok = (int'(item_row) < MAX_ROWS) && (int'(item_col) < MAX_COLS);
    assign ld_r  = RW'(item_row);
    assign ld_c  = CW'(item_col);

    // Neighbour of the current best cell in direction k.
    always_comb
    begin
        tr        = best_r_reg;
        tc        = best_c_reg;
        nb_inside = 1'b0;
        case (k_reg)
            NB_DOWN:
            begin
                tr        = best_r_reg + RW'(1);
                nb_inside = (NRW'(best_r_reg) + NRW'(1)) < nr;
            end
            NB_UP:
            begin
                tr        = best_r_reg - RW'(1);
                nb_inside = (best_r_reg != '0);
            end
            NB_RIGHT:
            begin
                tc        = best_c_reg + CW'(1);
                nb_inside = (NCW'(best_c_reg) + NCW'(1)) < nc;
            end
            NB_LEFT:
            begin
                tc        = best_c_reg - CW'(1);
                nb_inside = (best_c_reg != '0);
            end
            default:
            begin
                nb_inside = 1'b0;
            end
        endcase
    end

    assign sts.nb_inside = nb_inside;

    assign nb_addr   = {tr, tc};
    assign scan_addr = {scan_r_reg, scan_c_reg};
    assign rd_addr   = cmd.scan ? scan_addr : nb_addr;
    assign row_end   = (NCW'(scan_c_reg) + NCW'(1)) == nc;
    assign scan_last = row_end && ((NRW'(scan_r_reg) + NRW'(1)) == nr);
    assign rd_f      = cost_rd_reg[FW-1:0];
    assign rd_g      = cost_rd_reg[GW+FW-1:FW];
    assign g_new     = best_g_reg + GW'(1);

    assign dr    = (tr > goal_r_reg) ? tr - goal_r_reg : goal_r_reg - tr;
    assign dc    = (tc > goal_c_reg) ? tc - goal_c_reg : goal_c_reg - tc;
    assign sum   = (SW'(dr) * SW'(dr)) + (SW'(dc) * SW'(dc));
    assign trial = root_reg | (HW'(1) << bi_reg);

    always_comb
    begin
        stat_we = 1'b0;
        stat_wa = nb_addr;
        stat_wd = 2'b00;
        if (cmd.clr)
        begin
            stat_we = 1'b1;
            stat_wa = clr_idx_reg;
            stat_wd = 2'b00;
        end
        else if (cmd.init)
        begin
            stat_we = 1'b1;
            stat_wa = '0;
            stat_wd = 2'b11;
        end
        else if (cmd.close)
        begin
            stat_we = 1'b1;
            stat_wa = {best_r_reg, best_c_reg};
            stat_wd = 2'b10;
        end
        else if (cmd.nb_write)
        begin
            stat_we = 1'b1;
            stat_wa = nb_addr;
            stat_wd = 2'b01;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && ld_ok)
        begin
            map_mem[{ld_r, ld_c}] <= item_kind;
        end
        map_rd_reg <= map_mem[nb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_wa] <= stat_wd;
        end
        stat_rd_reg <= stat_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            cost_mem[0] <= '0;
        end
        else if (cmd.nb_write)
        begin
            cost_mem[nb_addr] <= {g_new, FW'(g_new) + FW'(root_reg)};
        end
        cost_rd_reg <= cost_mem[rd_addr];
    end

    assign sts.clr_last  = (clr_idx_reg == '1);
    assign sts.scan_done = issue_done_reg && !pv_reg;
    assign sts.have      = have_reg;
    assign sts.at_goal   = (best_r_reg == goal_r_reg) && (best_c_reg == goal_c_reg);
    assign sts.nb_free   = (stat_rd_reg == 2'b00)
                        && ((map_rd_reg == KIND_FREE) || (map_rd_reg == KIND_GOAL));
    assign sts.nb_last   = (k_reg == NB_LEFT);
    assign sts.h_last    = (bi_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_r_reg     <= '0;
            goal_c_reg     <= '0;
            clr_idx_reg    <= '0;
            scan_r_reg     <= '0;
            scan_c_reg     <= '0;
            issue_done_reg <= 1'b0;
            pv_reg         <= 1'b0;
            have_reg       <= 1'b0;
            first_reg      <= 1'b0;
            cnt_reg        <= '0;
            k_reg          <= NB_DOWN;
            bi_reg         <= '0;
        end
        else
        begin
            if (cmd.load && ld_ok && (item_kind == KIND_GOAL))
            begin
                goal_r_reg <= ld_r;
                goal_c_reg <= ld_c;
            end
            if (cmd.clr)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (cmd.init)
            begin
                cnt_reg   <= (AW+1)'(1);
                first_reg <= 1'b1;
            end
            if (cmd.scan_rst)
            begin
                scan_r_reg     <= '0;
                scan_c_reg     <= '0;
                issue_done_reg <= 1'b0;
                pv_reg         <= 1'b0;
                have_reg       <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pv_reg <= !issue_done_reg;
                if (!issue_done_reg)
                begin
                    if (scan_last)
                    begin
                        issue_done_reg <= 1'b1;
                    end
                    else if (row_end)
                    begin
                        scan_c_reg <= '0;
                        scan_r_reg <= scan_r_reg + RW'(1);
                    end
                    else
                    begin
                        scan_c_reg <= scan_c_reg + CW'(1);
                    end
                end
                // Strict compare keeps the lowest row-major index on equal cost.
                if (pv_reg && stat_rd_reg[0] && (!have_reg || (rd_f < best_f_reg)))
                begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.close)
            begin
                k_reg <= NB_DOWN;
                if (first_reg)
                    first_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            else if (cmd.nb_next)
            begin
                k_reg <= nb_dir_t'(k_reg + 2'd1);
            end
            if (cmd.h_load)
            begin
                bi_reg <= BW'(HW - 1);
            end
            else if (cmd.h_step)
            begin
                bi_reg <= bi_reg - BW'(1);
            end
        end
    end

    // Payload registers: best cell, root trial and result.
    assign plen_x = XW'(best_g_reg) + XW'(1);
    assign cnt_x  = XW'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.scan && pv_reg && stat_rd_reg[0] && (!have_reg || (rd_f < best_f_reg)))
        begin
            best_r_reg <= pr_reg;
            best_c_reg <= pc_reg;
            best_f_reg <= rd_f;
            best_g_reg <= rd_g;
        end
        pr_reg <= scan_r_reg;
        pc_reg <= scan_c_reg;
        if (cmd.h_load)
        begin
            sum_reg  <= sum;
            root_reg <= '0;
        end
        else if (cmd.h_step)
        begin
            if ((PW'(trial) * PW'(trial)) <= PW'(sum_reg))
            begin
                root_reg <= trial;
            end
        end
        if (cmd.res_load)
        begin
            res_found <= have_reg && sts.at_goal;
            if (have_reg && sts.at_goal)
                res_path_length <= (plen_x > XW'(COUNT_MAX)) ? COUNT_MAX : plen_x[OUT_W-1:0];
            else
                res_path_length <= '0;
            res_closed_count <= (cnt_x > XW'(COUNT_MAX)) ? COUNT_MAX : cnt_x[OUT_W-1:0];
        end
    end

`ifndef NO_ASSERTIONS
    a_open_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nb_write |-> (stat_rd_reg == 2'b00))
        else $error("neighbour opened although already marked");
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nb_write |-> ((PW'(root_reg) * PW'(root_reg)) <= PW'(sum_reg)))
        else $error("distance estimate above the true root");
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !stat_we)
        else $error("mark memory written during the open-cell scan");
`endif

endmodule

// ----- hw/rtl/grid_best_first_path_search.sv -----
// Top level of the grid best-first path search, with the register port.
// Depends on gbfs_pkg, gbfs_if, gbfs_ctrl and gbfs_datapath.
//
// Requests arrive on the item channel. A load request (op 0) writes one
// maze cell; loads stream at one per cycle while no run is in progress.
// A run request (op 1) searches from cell (0,0) to the last goal loaded and
// gives one result on the result channel; loads give none.
// A run first sweeps all 2**(RW+CW) mark memory entries, one entry a cycle.
// Each best-first step then scans the used area through the memory read
// port, picks the best open cell, and visits its four neighbours; each free
// unmarked neighbour is costed by a bit-serial root of HW bits, where HW is
// the distance root width (7 bits for a 64 by 64 grid). Item ready stays
// low until the result is written.
// The result sits in an output register; while it waits, further loads are
// accepted, and a following run finishes its search before waiting for it.
// Reset clears the control state, the goal (0,0) and sets both size
// registers to 64; maze contents are undefined until loaded.
module grid_best_first_path_search #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gbfs_item_if.sink                  item,
    gbfs_result_if.source              result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import gbfs_pkg::*;

    logic [CFG_W-1:0] rows_used_reg, cols_used_reg;
    reg_idx_t         reg_idx;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= CFG_RESET;
            cols_used_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_ROWS_USED: rows_used_reg <= pwdata[CFG_W-1:0];
                REG_COLS_USED: cols_used_reg <= pwdata[CFG_W-1:0];
                default:       rows_used_reg <= rows_used_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROWS_USED: prdata = 32'(rows_used_reg);
            REG_COLS_USED: prdata = 32'(cols_used_reg);
            default:       prdata = '0;
        endcase
    end

    gbfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_op      (item.op),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    gbfs_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .item_row         (item.row),
        .item_col         (item.col),
        .item_kind        (item.cell_kind),
        .rows_used        (rows_used_reg),
        .cols_used        (cols_used_reg),
        .res_found        (result.found),
        .res_path_length  (result.path_length),
        .res_closed_count (result.closed_count)
    );

endmodule

// ----- dv/gbfs_tb_pkg.sv -----
// Predictor and result checker for the grid best-first path search testbench.
// Depends on gbfs_pkg for field widths, kinds and operation codes.
`timescale 1ns / 100ps
package gbfs_tb_pkg;
    import gbfs_pkg::*;

    typedef struct {
        logic             found;
        logic [OUT_W-1:0] path_length;
        logic [OUT_W-1:0] closed_count;
    } search_res_t;

    class search_scoreboard;
        localparam int GRID_DIM = 64;

        logic [KIND_W-1:0] maze [GRID_DIM*GRID_DIM];
        int                goal_r;
        int                goal_c;
        logic [CFG_W-1:0]  rows_reg;
        logic [CFG_W-1:0]  cols_reg;
        search_res_t       awaited [$];
        int                errors;

        function new();
            goal_r   = 0;
            goal_c   = 0;
            rows_reg = CFG_RESET;
            cols_reg = CFG_RESET;
            errors   = 0;
            foreach (maze[i])
                maze[i] = KIND_FREE;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
            if (idx == REG_ROWS_USED)
                rows_reg = v;
            else
                cols_reg = v;
        endfunction

        function int root_floor(int v);
            int s;
            s = 0;
            while ((s + 1) * (s + 1) <= v)
                s++;
            return s;
        endfunction

        function int clamp_dim(logic [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > GRID_DIM)
                return GRID_DIM;
            return int'(v);
        endfunction

        function search_res_t search();
            bit          opn  [GRID_DIM*GRID_DIM];
            bit          cls  [GRID_DIM*GRID_DIM];
            int          g    [GRID_DIM*GRID_DIM];
            int          nr, nc, br, bc, bf, f, dr, dc, tr, tc, ti, bi, cnt;
            bit          have;
            search_res_t res;
            nr = clamp_dim(rows_reg);
            nc = clamp_dim(cols_reg);
            foreach (opn[i])
            begin
                opn[i] = 0;
                cls[i] = 0;
                g[i]   = 0;
            end
            opn[0] = 1;
            cls[0] = 1;
            res.found       = 1'b0;
            res.path_length = '0;
            forever
            begin
                have = 0;
                br = 0;
                bc = 0;
                bf = 0;
                for (int r = 0; r < nr; r++)
                    for (int c = 0; c < nc; c++)
                        if (opn[r*GRID_DIM+c])
                        begin
                            dr = r - goal_r;
                            dc = c - goal_c;
                            f = g[r*GRID_DIM+c] + root_floor(dr*dr + dc*dc);
                            if (!have || f < bf)
                            begin
                                have = 1;
                                bf = f;
                                br = r;
                                bc = c;
                            end
                        end
                if (!have)
                    break;
                bi = br*GRID_DIM + bc;
                if (br == goal_r && bc == goal_c)
                begin
                    res.found       = 1'b1;
                    res.path_length = OUT_W'(g[bi] + 1);
                    break;
                end
                opn[bi] = 0;
                cls[bi] = 1;
                for (int k = 0; k < 4; k++)
                begin
                    tr = br + (k == 0 ? 1 : k == 1 ? -1 : 0);
                    tc = bc + (k == 2 ? 1 : k == 3 ? -1 : 0);
                    if (tr < 0 || tc < 0 || tr >= nr || tc >= nc)
                        continue;
                    ti = tr*GRID_DIM + tc;
                    if (opn[ti] || cls[ti])
                        continue;
                    if (maze[ti] == KIND_FREE || maze[ti] == KIND_GOAL)
                    begin
                        opn[ti] = 1;
                        g[ti]   = g[bi] + 1;
                    end
                end
            end
            cnt = 0;
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                    if (cls[r*GRID_DIM+c])
                        cnt++;
            res.closed_count = OUT_W'(cnt);
            return res;
        endfunction

        function void note_request(op_t op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                   logic [KIND_W-1:0] kind);
            if (op == OP_LOAD)
            begin
                maze[row*GRID_DIM + col] = kind;
                if (kind == KIND_GOAL)
                begin
                    goal_r = row;
                    goal_c = col;
                end
            end
            else
                awaited = {awaited, search()};
        endfunction

        task report(string what);
            $display("ERROR at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic found, logic [OUT_W-1:0] plen,
                          logic [OUT_W-1:0] closed);
            search_res_t e;
            if (awaited.size() == 0)
            begin
                report("result arrived with none outstanding");
                return;
            end
            e = awaited.pop_front();
            if (found !== e.found)
                report($sformatf("found %0b, predicted %0b", found, e.found));
            if (plen !== e.path_length)
                report($sformatf("path_length %0d, predicted %0d", plen, e.path_length));
            if (closed !== e.closed_count)
                report($sformatf("closed_count %0d, predicted %0d", closed, e.closed_count));
        endtask
    endclass
endpackage

// ----- dv/tb.sv -----
// Top level of the grid best-first path search testbench: clock, reset,
// request and register drivers, result sink. Depends on gbfs_pkg, gbfs_if, gbfs_tb_pkg.
`timescale 1ns / 100ps
module tb;
    import gbfs_pkg::*;
    import gbfs_tb_pkg::*;

    localparam int CYCLE_LIMIT = 12000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gbfs_item_if   item ();
    gbfs_result_if result ();

    grid_best_first_path_search dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item.sink),
        .result  (result.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    search_scoreboard sb;
    bit   written [64*64];
    int   requests_sent;
    int   area_rows;
    int   area_cols;
    bit   no_gaps;
    bit   sink_no_stall;
    int   sink_stall;
    int   cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result sink: after each accepted result, hold ready low for a random stall unless stalls are off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                sb.check_result(result.found, result.path_length, result.closed_count);
                sink_stall = sink_no_stall ? 0 : $urandom_range(0, 14);
            end
            else if (sink_stall > 0)
                sink_stall--;
            if ($urandom_range(0, 99) == 0)
                sink_no_stall = ~sink_no_stall;
            result.ready <= (sink_stall == 0);
        end
    end

    task automatic send(op_t op, int row, int col, logic [KIND_W-1:0] kind);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        repeat (gap)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid     <= 1'b1;
        item.op        <= op;
        item.row       <= ROW_W'(row);
        item.col       <= COL_W'(col);
        item.cell_kind <= kind;
        do
            @(posedge clk);
        while (!item.ready);
        sb.note_request(op, ROW_W'(row), COL_W'(col), kind);
        if (op == OP_LOAD)
            written[row*64 + col] = 1;
        requests_sent++;
    endtask

    task automatic load(int row, int col, logic [KIND_W-1:0] kind);
        send(OP_LOAD, row, col, kind);
    endtask

    task automatic run_search();
        send(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), 2'($urandom_range(0, 3)));
    endtask

    // Configuration changes only once every result is home and the block is quiet.
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {1'(idx), 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, CFG_W'(value));
    endtask

    function automatic logic [KIND_W-1:0] rand_kind();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return KIND_FREE;
        if (p < 85)
            return KIND_WALL;
        if (p < 95)
            return KIND_GOAL;
        return 2'd3;
    endfunction

    // Every cell a search could look at must have been loaded first.
    task automatic fill_area();
        for (int r = 0; r < area_rows; r++)
            for (int c = 0; c < area_cols; c++)
                if (!written[r*64 + c])
                    load(r, c, ($urandom_range(0, 99) < 78) ? KIND_FREE : KIND_WALL);
    endtask

    initial
    begin
        int shape;
        int burst;
        sb = new();
        cycles        = 0;
        requests_sent = 0;
        no_gaps       = 0;
        sink_no_stall = 0;
        sink_stall    = 0;
        rst_n          = 1'b0;
        item.valid     = 1'b0;
        item.op        = OP_LOAD;
        item.row       = '0;
        item.col       = '0;
        item.cell_kind = KIND_FREE;
        result.ready   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No goal loaded yet, so the goal is the start cell.
        run_search();
        load(0, 1, KIND_WALL);
        load(1, 0, 2'd3);
        load(63, 0, KIND_FREE);
        load(0, 63, KIND_FREE);
        load(63, 63, KIND_GOAL);
        run_search();
        load(0, 0, KIND_GOAL);
        run_search();
        load(0, 0, KIND_WALL);
        run_search();
        load(42, 21, KIND_GOAL);
        drain();
        write_reg(REG_ROWS_USED, 0);
        write_reg(REG_COLS_USED, 0);
        run_search();
        drain();
        write_reg(REG_ROWS_USED, 127);
        write_reg(REG_COLS_USED, 127);
        run_search();
        drain();
        write_reg(REG_ROWS_USED, 3);
        write_reg(REG_COLS_USED, 3);
        area_rows = 3;
        area_cols = 3;
        load(0, 1, KIND_FREE);
        load(1, 0, KIND_FREE);
        fill_area();
        load(2, 2, KIND_GOAL);
        run_search();
        load(2, 2, KIND_WALL);
        run_search();
        load(1, 1, KIND_GOAL);
        run_search();
        // Hold the sender back until every result is in.
        drain();

        while (requests_sent < 1700)
        begin
            shape = $urandom_range(0, 9);
            if (shape == 0)
            begin
                area_rows = 64;
                area_cols = 1;
            end
            else if (shape == 1)
            begin
                area_rows = 1;
                area_cols = 64;
            end
            else
            begin
                area_rows = $urandom_range(1, 8);
                area_cols = $urandom_range(1, 8);
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            write_reg(REG_ROWS_USED, area_rows);
            write_reg(REG_COLS_USED, area_cols);
            fill_area();
            load($urandom_range(0, area_rows - 1), $urandom_range(0, area_cols - 1),
                 KIND_GOAL);
            run_search();
            burst = $urandom_range(40, 80);
            repeat (burst)
            begin
                if ($urandom_range(0, 11) == 0)
                    run_search();
                else if ($urandom_range(0, 9) < 7)
                    load($urandom_range(0, area_rows - 1), $urandom_range(0, area_cols - 1),
                         rand_kind());
                else
                    load($urandom_range(0, 63), $urandom_range(0, 63), rand_kind());
            end
            run_search();
            drain();
        end

        repeat (50)
            @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
